>>> hw/rtl/lpg_pkg.sv
`default_nettype none

package lpg_pkg;

    // Fixed field widths
    localparam int PITCH_W     = 13;
    localparam int OFF_W       = 24;
    localparam int COLOR_W     = 8;
    localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd640;

    // What one queued command asks of the stepper
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_LOAD = 2'd1,
        OP_DROP = 2'd2
    } t_op;

    // Line classes
    typedef enum logic [1:0] {
        KIND_HORIZ  = 2'd0,
        KIND_VERT   = 2'd1,
        KIND_COLMAJ = 2'd2,
        KIND_ROWMAJ = 2'd3
    } t_kind;

    typedef struct packed {
        t_op   op;
        t_kind kind;
        logic  step_left;
    } t_cmd_ctl;

    localparam int CTL_W = $bits(t_cmd_ctl);

endpackage

`default_nettype wire

>>> hw/rtl/lpg_front.sv
`default_nettype none

module lpg_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input beat
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_new_line,
    input  logic signed [COORD_BITS:0]       i_x_start,
    input  logic signed [COORD_BITS:0]       i_y_start,
    input  logic signed [COORD_BITS:0]       i_x_finish,
    input  logic signed [COORD_BITS:0]       i_y_finish,
    input  logic [lpg_pkg::COLOR_W-1:0]      i_color_in,
    input  logic                             i_xor_in,
    input  logic [lpg_pkg::PITCH_W-1:0]      i_row_pitch,
    // command out to the queue
    output logic                             o_cmd_valid,
    input  logic                             i_cmd_ready,
    output lpg_pkg::t_cmd_ctl                o_cmd_ctl,
    output logic [COORD_BITS-1:0]            o_x1,
    output logic [COORD_BITS-1:0]            o_y1,
    output logic [COORD_BITS-1:0]            o_run,
    output logic [COORD_BITS-1:0]            o_rise,
    output logic [COORD_BITS:0]              o_count,
    output logic [lpg_pkg::OFF_W-1:0]        o_offset,
    output logic [lpg_pkg::COLOR_W-1:0]      o_color,
    output logic                             o_xor
);

    localparam int CB    = COORD_BITS;
    localparam int OFF_W = lpg_pkg::OFF_W;

    // stage 1: ordered endpoints
    logic                            r1_valid, n1_valid;
    lpg_pkg::t_op                    r1_op, n1_op;
    logic [CB-1:0]                   r1_xa, r1_ya, r1_xb, r1_yb;
    logic [CB-1:0]                   n1_xa, n1_ya, n1_xb, n1_yb;
    logic [lpg_pkg::COLOR_W-1:0]     r1_color;
    logic                            r1_xor;

    // stage 2: classified command
    logic                            r2_valid, n2_valid;
    lpg_pkg::t_cmd_ctl               r2_ctl, n2_ctl;
    logic [CB-1:0]                   r2_x1, r2_y1, r2_run, r2_rise;
    logic [CB-1:0]                   n2_run, n2_rise;
    logic [CB:0]                     r2_count, n2_count;
    logic [OFF_W-1:0]                r2_offset, n2_offset;
    logic [lpg_pkg::COLOR_W-1:0]     r2_color;
    logic                            r2_xor;

    logic adv1, adv2, accept;
    logic neg_any, keep_order;
    logic [CB-1:0] xs, ys, xf, yf;

    // elastic pipeline handshake
    assign adv2    = !r2_valid || i_cmd_ready;
    assign adv1    = !r1_valid || adv2;
    assign o_stall = !adv1;
    assign accept  = i_valid && adv1;

    assign xs = i_x_start[CB-1:0];
    assign ys = i_y_start[CB-1:0];
    assign xf = i_x_finish[CB-1:0];
    assign yf = i_y_finish[CB-1:0];

    // stage 1: sign check, top-to-bottom then left-to-right order
    always_comb begin
        neg_any    = i_x_start[CB] | i_y_start[CB] | i_x_finish[CB] | i_y_finish[CB];
        keep_order = (ys < yf) || ((ys == yf) && (xs < xf));
        if (!i_new_line) begin
            n1_op = lpg_pkg::OP_TICK;
        end else if (neg_any) begin
            n1_op = lpg_pkg::OP_DROP;
        end else begin
            n1_op = lpg_pkg::OP_LOAD;
        end
        n1_xa = keep_order ? xs : xf;
        n1_ya = keep_order ? ys : yf;
        n1_xb = keep_order ? xf : xs;
        n1_yb = keep_order ? yf : ys;
        n1_valid = accept ? 1'b1 : (adv1 ? 1'b0 : r1_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= n1_valid;
        end
        if (accept) begin
            r1_op    <= n1_op;
            r1_xa    <= n1_xa;
            r1_ya    <= n1_ya;
            r1_xb    <= n1_xb;
            r1_yb    <= n1_yb;
            r1_color <= i_color_in;
            r1_xor   <= i_xor_in;
        end
    end

    // stage 2: spans, class, pixel count and start offset
    always_comb begin
        n2_ctl.op        = r1_op;
        n2_ctl.step_left = r1_xb < r1_xa;
        n2_rise          = r1_yb - r1_ya;
        n2_run           = n2_ctl.step_left ? (r1_xa - r1_xb) : (r1_xb - r1_xa);
        if (n2_rise == '0) begin
            n2_ctl.kind = lpg_pkg::KIND_HORIZ;
            n2_count    = {1'b0, n2_run} + (CB+1)'(1);
        end else if (n2_run == '0) begin
            n2_ctl.kind = lpg_pkg::KIND_VERT;
            n2_count    = {1'b0, n2_rise};
        end else if (n2_run > n2_rise) begin
            n2_ctl.kind = lpg_pkg::KIND_COLMAJ;
            n2_count    = {1'b0, n2_run};
        end else begin
            n2_ctl.kind = lpg_pkg::KIND_ROWMAJ;
            n2_count    = {1'b0, n2_rise};
        end
        n2_offset = OFF_W'(r1_ya) * OFF_W'(i_row_pitch) + OFF_W'(r1_xa);
        n2_valid  = adv2 ? r1_valid : r2_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= n2_valid;
        end
        if (adv2 && r1_valid) begin
            r2_ctl    <= n2_ctl;
            r2_x1     <= r1_xa;
            r2_y1     <= r1_ya;
            r2_run    <= n2_run;
            r2_rise   <= n2_rise;
            r2_count  <= n2_count;
            r2_offset <= n2_offset;
            r2_color  <= r1_color;
            r2_xor    <= r1_xor;
        end
    end

    assign o_cmd_valid = r2_valid;
    assign o_cmd_ctl   = r2_ctl;
    assign o_x1        = r2_x1;
    assign o_y1        = r2_y1;
    assign o_run       = r2_run;
    assign o_rise      = r2_rise;
    assign o_count     = r2_count;
    assign o_offset    = r2_offset;
    assign o_color     = r2_color;
    assign o_xor       = r2_xor;

endmodule

`default_nettype wire

>>> hw/rtl/lpg_queue.sv
`default_nettype none

module lpg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // pointer wrap and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lpg_back.sv
`default_nettype none

module lpg_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command from the queue
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_pop,
    input  lpg_pkg::t_cmd_ctl             i_cmd_ctl,
    input  logic [COORD_BITS-1:0]         i_x1,
    input  logic [COORD_BITS-1:0]         i_y1,
    input  logic [COORD_BITS-1:0]         i_run,
    input  logic [COORD_BITS-1:0]         i_rise,
    input  logic [COORD_BITS:0]           i_count,
    input  logic [lpg_pkg::OFF_W-1:0]     i_offset,
    input  logic [lpg_pkg::COLOR_W-1:0]   i_color,
    input  logic                          i_xor,
    input  logic [lpg_pkg::PITCH_W-1:0]   i_row_pitch,
    // pixel beat
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [COORD_BITS-1:0]         o_pixel_x,
    output logic [COORD_BITS-1:0]         o_pixel_y,
    output logic [lpg_pkg::OFF_W-1:0]     o_pixel_offset,
    output logic [lpg_pkg::COLOR_W-1:0]   o_color_out,
    output logic                          o_combine_xor,
    output logic                          o_last_pixel
);

    localparam int CB    = COORD_BITS;
    localparam int DW    = COORD_BITS + 2;
    localparam int OFF_W = lpg_pkg::OFF_W;

    // line state; r_diff holds minor minus major accumulator
    logic                        r_active, n_active;
    lpg_pkg::t_kind              r_kind;
    logic                        r_step_left;
    logic [CB-1:0]               r_col, r_row, r_run, r_rise;
    logic [OFF_W-1:0]            r_offset;
    logic [DW-1:0]               r_diff;
    logic [CB:0]                 r_left;
    logic [lpg_pkg::COLOR_W-1:0] r_color;
    logic                        r_xor;

    // output register
    logic                        r_out_valid, n_out_valid;
    logic [CB-1:0]               r_px, r_py;
    logic [OFF_W-1:0]            r_poff;
    logic [lpg_pkg::COLOR_W-1:0] r_pcolor;
    logic                        r_pxor, r_plast;

    // step source: queue entry on load, held state on tick
    logic                        is_load, is_tick, is_drop, emit, out_free, pop;
    lpg_pkg::t_kind              s_kind;
    logic                        s_left;
    logic [CB-1:0]               s_col, s_row, s_run, s_rise;
    logic [OFF_W-1:0]            s_offset;
    logic [DW-1:0]               s_diff;
    logic [CB:0]                 s_left_dec;
    lpg_pkg::t_cmd_ctl           ctl;

    // one step of the line
    logic                        diff_pos, col_step, row_step;
    logic [DW-1:0]               diff_inc, diff_dec;
    logic [CB-1:0]               n_col, n_row;
    logic [OFF_W-1:0]            n_offset, col_delta, row_delta;
    logic [DW-1:0]               n_diff;

    assign ctl      = i_cmd_ctl;
    assign out_free = !r_out_valid || !i_stall;
    assign pop      = i_cmd_valid && out_free;
    assign is_load  = ctl.op == lpg_pkg::OP_LOAD;
    assign is_tick  = ctl.op == lpg_pkg::OP_TICK;
    assign is_drop  = ctl.op == lpg_pkg::OP_DROP;
    assign emit     = is_load || (is_tick && r_active);

    // source select
    always_comb begin
        if (is_load) begin
            s_kind     = ctl.kind;
            s_left     = ctl.step_left;
            s_col      = i_x1;
            s_row      = i_y1;
            s_run      = i_run;
            s_rise     = i_rise;
            s_offset   = i_offset;
            s_diff     = '0;
            s_left_dec = i_count - (CB+1)'(1);
        end else begin
            s_kind     = r_kind;
            s_left     = r_step_left;
            s_col      = r_col;
            s_row      = r_row;
            s_run      = r_run;
            s_rise     = r_rise;
            s_offset   = r_offset;
            s_diff     = r_diff;
            s_left_dec = r_left - (CB+1)'(1);
        end
    end

    // decide which axes step and how the accumulators move
    always_comb begin
        diff_pos = !s_diff[DW-1] && (s_diff != '0);
        col_step = 1'b0;
        row_step = 1'b0;
        diff_inc = '0;
        diff_dec = '0;
        unique case (s_kind)
            lpg_pkg::KIND_HORIZ: begin
                col_step = 1'b1;
            end
            lpg_pkg::KIND_VERT: begin
                row_step = 1'b1;
            end
            lpg_pkg::KIND_COLMAJ: begin
                col_step = 1'b1;
                row_step = diff_pos;
                diff_inc = {2'b00, s_rise};
                diff_dec = diff_pos ? {2'b00, s_run} : '0;
            end
            default: begin
                row_step = 1'b1;
                col_step = diff_pos;
                diff_inc = {2'b00, s_run};
                diff_dec = diff_pos ? {2'b00, s_rise} : '0;
            end
        endcase
        if (!col_step) begin
            n_col     = s_col;
            col_delta = '0;
        end else if (s_left) begin
            n_col     = s_col - CB'(1);
            col_delta = {OFF_W{1'b1}};
        end else begin
            n_col     = s_col + CB'(1);
            col_delta = OFF_W'(1);
        end
        n_row     = row_step ? (s_row + CB'(1)) : s_row;
        row_delta = row_step ? OFF_W'(i_row_pitch) : '0;
        n_offset  = s_offset + col_delta + row_delta;
        n_diff    = s_diff + diff_inc - diff_dec;
    end

    // active flag and output slot
    always_comb begin
        n_active = r_active;
        if (pop && is_drop) begin
            n_active = 1'b0;
        end else if (pop && emit) begin
            n_active = s_left_dec != '0;
        end
        n_out_valid = out_free ? (pop && emit) : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
        if (pop && emit) begin
            r_kind      <= s_kind;
            r_step_left <= s_left;
            r_run       <= s_run;
            r_rise      <= s_rise;
            r_col       <= n_col;
            r_row       <= n_row;
            r_offset    <= n_offset;
            r_diff      <= n_diff;
            r_left      <= s_left_dec;
            r_px        <= s_col;
            r_py        <= s_row;
            r_poff      <= s_offset;
            r_plast     <= s_left_dec == '0;
            r_pcolor    <= is_load ? i_color : r_color;
            r_pxor      <= is_load ? i_xor : r_xor;
            if (is_load) begin
                r_color <= i_color;
                r_xor   <= i_xor;
            end
        end
    end

    assign o_cmd_pop      = pop;
    assign o_valid        = r_out_valid;
    assign o_pixel_x      = r_px;
    assign o_pixel_y      = r_py;
    assign o_pixel_offset = r_poff;
    assign o_color_out    = r_pcolor;
    assign o_combine_xor  = r_pxor;
    assign o_last_pixel   = r_plast;

endmodule

`default_nettype wire

>>> hw/rtl/line_pixel_generator.sv
`default_nettype none

// Line pixel generator. A beat with new_line set loads two endpoints, a color
// and a write-or-xor flag and yields the line's first pixel; each later beat
// with new_line clear yields the next pixel, with last_pixel on the final one.
// A negative coordinate drops the line, and a new line replaces an unfinished
// one. Rate: one input beat per cycle unless the output stalls, one pixel per
// beat. The front end orders and classifies endpoints and forms the start
// offset (one multiply by row_pitch), a four-entry queue decouples it from the
// stepper, and the stepper's accumulator and offset update sets the per-pixel
// rate. row_pitch is to be written by the user through the config port only
// while idle; the block itself does not enforce this.
module line_pixel_generator #(
    parameter int COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_new_line,
    input  logic signed [COORD_BITS:0]    i_x_start,
    input  logic signed [COORD_BITS:0]    i_y_start,
    input  logic signed [COORD_BITS:0]    i_x_finish,
    input  logic signed [COORD_BITS:0]    i_y_finish,
    input  logic [lpg_pkg::COLOR_W-1:0]   i_color_in,
    input  logic                          i_xor_in,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [COORD_BITS-1:0]         o_pixel_x,
    output logic [COORD_BITS-1:0]         o_pixel_y,
    output logic [lpg_pkg::OFF_W-1:0]     o_pixel_offset,
    output logic [lpg_pkg::COLOR_W-1:0]   o_color_out,
    output logic                          o_combine_xor,
    output logic                          o_last_pixel,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lpg_pkg::PITCH_W-1:0]   i_cfg_data
);

    localparam int CB      = COORD_BITS;
    localparam int Q_DEPTH = 4;
    localparam int DATA_W  = 4 * CB + (CB + 1) + lpg_pkg::OFF_W + lpg_pkg::COLOR_W + 1;
    localparam int Q_W     = lpg_pkg::CTL_W + DATA_W;

    logic [lpg_pkg::PITCH_W-1:0] r_row_pitch;

    logic                        f_valid, q_ready, q_valid, q_pop;
    lpg_pkg::t_cmd_ctl           f_ctl, q_ctl;
    logic [CB-1:0]               f_x1, f_y1, f_run, f_rise;
    logic [CB-1:0]               q_x1, q_y1, q_run, q_rise;
    logic [CB:0]                 f_count, q_count;
    logic [lpg_pkg::OFF_W-1:0]   f_offset, q_offset;
    logic [lpg_pkg::COLOR_W-1:0] f_color, q_color;
    logic                        f_xor, q_xor;
    logic [Q_W-1:0]              q_in, q_out;

    // pitch register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pitch <= lpg_pkg::PITCH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_row_pitch <= i_cfg_data;
        end
    end

    lpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_new_line  (i_new_line),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_finish  (i_x_finish),
        .i_y_finish  (i_y_finish),
        .i_color_in  (i_color_in),
        .i_xor_in    (i_xor_in),
        .i_row_pitch (r_row_pitch),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (q_ready),
        .o_cmd_ctl   (f_ctl),
        .o_x1        (f_x1),
        .o_y1        (f_y1),
        .o_run       (f_run),
        .o_rise      (f_rise),
        .o_count     (f_count),
        .o_offset    (f_offset),
        .o_color     (f_color),
        .o_xor       (f_xor)
    );

    // command queue between front end and stepper
    assign q_in = {f_ctl, f_x1, f_y1, f_run, f_rise, f_count, f_offset, f_color, f_xor};

    lpg_queue #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (q_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    assign {q_ctl, q_x1, q_y1, q_run, q_rise, q_count, q_offset, q_color, q_xor} = q_out;

    lpg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .o_cmd_pop      (q_pop),
        .i_cmd_ctl      (q_ctl),
        .i_x1           (q_x1),
        .i_y1           (q_y1),
        .i_run          (q_run),
        .i_rise         (q_rise),
        .i_count        (q_count),
        .i_offset       (q_offset),
        .i_color        (q_color),
        .i_xor          (q_xor),
        .i_row_pitch    (r_row_pitch),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_offset (o_pixel_offset),
        .o_color_out    (o_color_out),
        .o_combine_xor  (o_combine_xor),
        .o_last_pixel   (o_last_pixel)
    );

endmodule

`default_nettype wire
